@@ rtl/c_comment_strip_minifier_unit_macros.svh @@
// Assertion macros used by the comment strip minifier top level.
`ifndef C_COMMENT_STRIP_MINIFIER_UNIT_MACROS_SVH
`define C_COMMENT_STRIP_MINIFIER_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CMS_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("cms invariant violated");

// Check that a trigger is followed by a consequence in the next cycle.
`define CMS_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("cms sequence check violated");

`endif

@@ rtl/cms_pkg.sv @@
// Types, character constants and judging function of the comment strip minifier.
package cms_pkg;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam int OUT_DEPTH = 4;
   localparam int PTR_W     = $clog2(OUT_DEPTH);
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic swallow_next;
      logic block_cmt;
      logic in_line;
      logic after_space;
   } cms_flags_type;

   typedef struct packed {
      logic [7:0]    held_char;
      logic          held_valid;
      cms_flags_type flags;
   } cms_state_type;

   typedef struct packed {
      cms_flags_type flags;
      logic          emit;
      logic [7:0]    out_byte;
   } cms_judge_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
   } cms_word_type;

   typedef struct packed {
      logic         push_a;
      logic         push_b;
      cms_word_type word_a;
      cms_word_type word_b;
   } cms_push_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             room;
   } cms_fifo_status_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_punct(logic [7:0] c);
      return (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
             (c == 8'h5B) || (c == 8'h5D) || (c == 8'h3B) || (c == 8'h2C) ||
             (c == 8'h2E);
   endfunction

   // Judge byte c against lookahead n; nv says whether a lookahead exists.
   function automatic cms_judge_type judge(cms_flags_type f, logic [7:0] c,
                                           logic [7:0] n, logic nv);
      cms_judge_type r;
      r.flags    = f;
      r.emit     = 1'b0;
      r.out_byte = c;
      if (f.swallow_next) begin
         r.flags.swallow_next = 1'b0;
      end else if (f.in_line) begin
         if (c == CH_NL) begin
            r.flags.in_line     = 1'b0;
            r.flags.after_space = 1'b1;
         end
      end else if (!f.block_cmt && c == CH_SLASH && nv && n == CH_SLASH) begin
         r.flags.in_line = 1'b1;
      end else if (!f.block_cmt && c == CH_SLASH && nv && n == CH_STAR) begin
         r.flags.block_cmt    = 1'b1;
         r.flags.swallow_next = 1'b1;
      end else if (f.block_cmt && c == CH_STAR && nv && n == CH_SLASH) begin
         r.flags.block_cmt    = 1'b0;
         r.flags.swallow_next = 1'b1;
      end else if (f.block_cmt) begin
         if (c == CH_NL) begin
            r.flags.after_space = 1'b1;
         end
      end else if (is_ws(c)) begin
         r.emit              = !f.after_space;
         r.out_byte          = CH_SPACE;
         r.flags.after_space = 1'b1;
      end else begin
         r.emit              = 1'b1;
         r.flags.after_space = is_punct(c);
      end
      return r;
   endfunction

endpackage

@@ rtl/cms_if.sv @@
// Valid/ready channel interfaces for source bytes and minified result words.
interface cms_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_stream;

   modport source (output valid, output in_byte, output end_of_stream, input ready);
   modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface cms_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_out;

   modport source (output valid, output out_byte, output last_out, input ready);
   modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

@@ rtl/c_comment_strip_minifier_unit.sv @@
// C comment stripper and whitespace minifier top level.
//
// req_chan carries one source byte per word with an end_of_stream flag; rsp_chan
// carries minified bytes, last_out marking the final word caused by one input.
// Each byte is held back until the next one arrives, so its result word is
// written into the queue when the following byte is taken; a byte flagged
// end_of_stream is judged at once and its words are queued when it is taken.
// Throughput: one input word per cycle while req_chan.ready is high. An input
// causes zero, one or two words; the result side moves one word a cycle,
// while the receiver is ready, through a four-word queue with a single read
// port, so long runs of inputs that cause two words are limited by the result side.
// req_chan.ready is high while the queue has space for two words, so input is
// still taken while a result waits. When the receiver stalls the queue fills and
// ready drops; nothing is lost or duplicated.
// Synchronous reset empties the queue, drops the held byte, leaves comments and
// sets the start-of-line state; the block is ready in the cycle after reset.
`include "c_comment_strip_minifier_unit_macros.svh"
module c_comment_strip_minifier_unit (
   input  logic      clock,
   input  logic      reset,
   cms_req_if.sink   req_chan,
   cms_rsp_if.source rsp_chan
);
   import cms_pkg::*;

   cms_push_type        step_push;
   cms_state_type       step_state;
   cms_fifo_status_type fifo_status;
   logic                req_accept;
   logic                eos_accept;
   logic                byte_accept;
   logic                flush_ok;
   logic                held_valid;
   logic [7:0]          held_char;

   assign req_chan.ready = fifo_status.room & !reset;
   assign req_accept     = req_chan.valid & req_chan.ready;

   cms_step u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_chan.in_byte),
      .end_of_stream (req_chan.end_of_stream),
      .push          (step_push),
      .state         (step_state)
   );

   cms_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (step_push),
      .rsp_chan (rsp_chan),
      .status   (fifo_status)
   );

   assign eos_accept  = req_accept & req_chan.end_of_stream;
   assign byte_accept = req_accept & !req_chan.end_of_stream;
   assign held_valid  = step_state.held_valid;
   assign held_char   = step_state.held_char;
   assign flush_ok    = !step_state.held_valid & step_state.flags.after_space &
                        !step_state.flags.in_line;

   `CMS_ASSERT_ALWAYS(a_count_bound, fifo_status.count <= CNT_W'(OUT_DEPTH))
   `CMS_ASSERT_NEXT(a_eos_flush, eos_accept, flush_ok)
   `CMS_ASSERT_NEXT(a_hold_byte, byte_accept, held_valid && (held_char == $past(req_chan.in_byte)))

endmodule

@@ rtl/cms_step.sv @@
// Lookahead register and per-byte judging logic; yields up to two result words.
module cms_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  end_of_stream,
   output cms_pkg::cms_push_type push,
   output cms_pkg::cms_state_type state
);
   import cms_pkg::*;

   cms_state_type state_ff, state_in;
   cms_judge_type held_j, last_j;
   cms_flags_type mid_flags;
   logic          emit_held, emit_last;

   always_comb begin
      // Judge the held byte with the new byte as lookahead.
      held_j    = judge(state_ff.flags, state_ff.held_char, in_byte, 1'b1);
      emit_held = state_ff.held_valid & held_j.emit;
      mid_flags = state_ff.held_valid ? held_j.flags : state_ff.flags;
      // On end of stream judge the new byte with no lookahead.
      last_j    = judge(mid_flags, in_byte, CH_NUL, 1'b0);
      emit_last = end_of_stream & last_j.emit;

      if (end_of_stream) begin
         state_in.held_char          = CH_NUL;
         state_in.held_valid         = 1'b0;
         state_in.flags.swallow_next = 1'b0;
         state_in.flags.block_cmt    = last_j.flags.block_cmt;
         state_in.flags.in_line      = 1'b0;
         state_in.flags.after_space  = 1'b1;
      end else begin
         state_in.held_char  = in_byte;
         state_in.held_valid = 1'b1;
         state_in.flags      = mid_flags;
      end

      push.push_a          = accept & (emit_held | emit_last);
      push.push_b          = accept & emit_held & emit_last;
      push.word_a.out_byte = emit_held ? held_j.out_byte : last_j.out_byte;
      push.word_a.last_out = !(emit_held & emit_last);
      push.word_b.out_byte = last_j.out_byte;
      push.word_b.last_out = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.held_char          <= CH_NUL;
         state_ff.held_valid         <= 1'b0;
         state_ff.flags.swallow_next <= 1'b0;
         state_ff.flags.block_cmt    <= 1'b0;
         state_ff.flags.in_line      <= 1'b0;
         state_ff.flags.after_space  <= 1'b1;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

@@ rtl/cms_out_fifo.sv @@
// Small result word queue: takes up to two words a cycle, delivers one while the receiver is ready.
module cms_out_fifo (
   input  logic                         clock,
   input  logic                         reset,
   input  cms_pkg::cms_push_type        push,
   cms_rsp_if.source                    rsp_chan,
   output cms_pkg::cms_fifo_status_type status
);
   import cms_pkg::*;

   cms_word_type     mem [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   cms_word_type     head;

   always_comb begin
      head              = mem[rd_ptr_ff];
      rsp_chan.valid    = (count_ff != '0);
      rsp_chan.out_byte = head.out_byte;
      rsp_chan.last_out = head.last_out;
      pop               = rsp_chan.valid & rsp_chan.ready;
      wr_ptr_in         = wr_ptr_ff + PTR_W'(push.push_a) + PTR_W'(push.push_b);
      rd_ptr_in         = rd_ptr_ff + PTR_W'(pop);
      count_in          = count_ff + CNT_W'(push.push_a) + CNT_W'(push.push_b)
                          - CNT_W'(pop);
      status.count      = count_ff;
      // Leave room for a two-word item regardless of this cycle's pop.
      status.room       = (count_ff <= CNT_W'(OUT_DEPTH - 2));
   end

   always_ff @(posedge clock) begin
      if (push.push_a) begin
         mem[wr_ptr_ff] <= push.word_a;
      end
      if (push.push_b) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= push.word_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
